// ===== src/tmal_pkg.sv =====
// tmal_pkg: shared constants, types and helper functions for the trimmed mean filter
// used by tmal_accum, tmal_scale and trimmed_mean_adc_level_pwm; no dependencies
package tmal_pkg;

    // group size and field widths
    localparam int SAMPLES_PER_RESULT = 10;
    localparam int SAMPLE_W           = 12;
    localparam int VAL_W              = 16;
    localparam int MASK_W             = 6;
    localparam int DUTY_W             = 12;
    localparam int LEVEL_W            = 8;
    localparam int CNT_W              = $clog2(SAMPLES_PER_RESULT);
    localparam int MAGIC_W            = 17;
    localparam int SHIFT_W            = 5;

    // port widths
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 40;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // reset values of the configuration registers
    localparam logic [SAMPLE_W-1:0] OFFSET_RESET = SAMPLE_W'(2000);
    localparam logic [VAL_W-1:0]    PERIOD_RESET = VAL_W'(512);

    localparam logic [SAMPLE_W-1:0] SMALLEST_RESET = '1;
    localparam logic [CNT_W-1:0]    LAST_COUNT     = CNT_W'(SAMPLES_PER_RESULT - 1);

    // constant divisors
    localparam int TRIM_DIV   = (SAMPLES_PER_RESULT > 2) ? (SAMPLES_PER_RESULT - 2) : 1;
    localparam int LEVEL_STEP = 350;
    localparam int DUTY_STEP  = 20;
    localparam int PCT_SCALE  = 100;

    // lowest filtered value that lights no led
    localparam logic [VAL_W-1:0] LED_LIMIT = VAL_W'(LEVEL_STEP * MASK_W);
    localparam logic [VAL_W-1:0] CMP_MAX   = VAL_W'(65535 / PCT_SCALE);

    // reciprocal constants: floor(x/d) = (x * m) >> (16 + l), l = clog2(d),
    // m = floor(2^(16+l)/d) + 1, exact for every 16-bit x
    localparam int TRIM_L  = $clog2(TRIM_DIV);
    localparam int LEVEL_L = $clog2(LEVEL_STEP);
    localparam int DUTY_L  = $clog2(DUTY_STEP);
    localparam int PCT_L   = $clog2(PCT_SCALE);

    localparam logic [MAGIC_W-1:0] TRIM_M  =
        MAGIC_W'(((64'd1 << (VAL_W + TRIM_L)) / TRIM_DIV) + 1);
    localparam logic [MAGIC_W-1:0] LEVEL_M =
        MAGIC_W'(((64'd1 << (VAL_W + LEVEL_L)) / LEVEL_STEP) + 1);
    localparam logic [MAGIC_W-1:0] DUTY_M  =
        MAGIC_W'(((64'd1 << (VAL_W + DUTY_L)) / DUTY_STEP) + 1);
    localparam logic [MAGIC_W-1:0] PCT_M   =
        MAGIC_W'(((64'd1 << (VAL_W + PCT_L)) / PCT_SCALE) + 1);

    localparam logic [SHIFT_W-1:0] TRIM_SH  = SHIFT_W'(VAL_W + TRIM_L);
    localparam logic [SHIFT_W-1:0] LEVEL_SH = SHIFT_W'(VAL_W + LEVEL_L);
    localparam logic [SHIFT_W-1:0] DUTY_SH  = SHIFT_W'(VAL_W + DUTY_L);
    localparam logic [SHIFT_W-1:0] PCT_SH   = SHIFT_W'(VAL_W + PCT_L);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OFFSET     = 4'd0,
        REG_PWM_PERIOD = 4'd1
    } cfg_reg_t;

    // accumulator status seen by the top level
    typedef struct packed {
        logic             grp_valid;
        logic [CNT_W-1:0] count;
    } acc_stat_t;

    // multiply by reciprocal and shift
    function automatic logic [VAL_W-1:0] div_by_const(
        input logic [VAL_W-1:0]   x,
        input logic [MAGIC_W-1:0] m,
        input logic [SHIFT_W-1:0] sh
    );
        logic [VAL_W+MAGIC_W-1:0] prod;
        prod = {{MAGIC_W{1'b0}}, x} * {{VAL_W{1'b0}}, m};
        div_by_const = VAL_W'(prod >> sh);
    endfunction

    // thermometer: bits 0..k lit when k is within the bar, else dark
    function automatic logic [MASK_W-1:0] level_mask(input logic [LEVEL_W-1:0] k);
        logic [MASK_W-1:0] mask;
        for (int i = 0; i < MASK_W; i++) begin
            mask[i] = (k <= LEVEL_W'(MASK_W - 1)) && (k >= LEVEL_W'(i));
        end
        level_mask = mask;
    endfunction

endpackage

// ===== src/tmal_accum.sv =====
// tmal_accum: running sum, minimum, maximum and count over one group of samples
// emits the untrimmed-by-division numerator (sum - min - max) in a group register
// depends on tmal_pkg
module tmal_accum (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [tmal_pkg::SAMPLE_W-1:0]  sample,
    input  logic                           grp_ready,
    output logic [tmal_pkg::VAL_W-1:0]     grp_num,
    output tmal_pkg::acc_stat_t            stat
);

    logic [tmal_pkg::VAL_W-1:0]    sum_reg, sum_next;
    logic [tmal_pkg::SAMPLE_W-1:0] min_reg, min_next;
    logic [tmal_pkg::SAMPLE_W-1:0] max_reg, max_next;
    logic [tmal_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic                          grp_valid_reg, grp_valid_next;
    logic [tmal_pkg::VAL_W-1:0]    num_reg, num_next;

    logic [tmal_pkg::VAL_W-1:0]    sum_add;
    logic [tmal_pkg::SAMPLE_W-1:0] min_upd, max_upd;
    logic                          accept, last;

    // only the closing sample of a group needs the group register free
    assign s_ready = (cnt_reg != tmal_pkg::LAST_COUNT) || !grp_valid_reg || grp_ready;
    assign accept  = s_valid && s_ready;
    assign last    = (cnt_reg == tmal_pkg::LAST_COUNT);

    always_comb begin
        sum_add = sum_reg + tmal_pkg::VAL_W'(sample);
        min_upd = (sample < min_reg) ? sample : min_reg;
        max_upd = (sample > max_reg) ? sample : max_reg;

        sum_next       = sum_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        cnt_next       = cnt_reg;
        grp_valid_next = grp_valid_reg;
        num_next       = num_reg;

        if (grp_ready) begin
            grp_valid_next = 1'b0;
        end

        if (accept) begin
            if (last) begin
                sum_next       = '0;
                min_next       = tmal_pkg::SMALLEST_RESET;
                max_next       = '0;
                cnt_next       = '0;
                grp_valid_next = 1'b1;
                num_next       = sum_add - tmal_pkg::VAL_W'(min_upd)
                                         - tmal_pkg::VAL_W'(max_upd);
            end else begin
                sum_next = sum_add;
                min_next = min_upd;
                max_next = max_upd;
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            min_reg       <= tmal_pkg::SMALLEST_RESET;
            max_reg       <= '0;
            cnt_reg       <= '0;
            grp_valid_reg <= 1'b0;
        end else begin
            sum_reg       <= sum_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            cnt_reg       <= cnt_next;
            grp_valid_reg <= grp_valid_next;
        end
        num_reg <= num_next;
    end

    assign grp_num        = num_reg;
    assign stat.grp_valid = grp_valid_reg;
    assign stat.count     = cnt_reg;

endmodule

// ===== src/tmal_scale.sv =====
// tmal_scale: four-stage result pipeline, divide by group size minus two, offset,
// level mask, duty, pwm product and percent scaling; ends in the output register
// depends on tmal_pkg
module tmal_scale (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           grp_valid,
    output logic                           grp_ready,
    input  logic [tmal_pkg::VAL_W-1:0]     grp_num,
    input  logic [tmal_pkg::SAMPLE_W-1:0]  offset,
    input  logic [tmal_pkg::VAL_W-1:0]     pwm_period,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [tmal_pkg::VAL_W-1:0]     filtered,
    output logic [tmal_pkg::MASK_W-1:0]    led_mask,
    output logic [tmal_pkg::VAL_W-1:0]     compare_value
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    logic [tmal_pkg::VAL_W-1:0]  filt1_reg, filt1_next;
    logic [tmal_pkg::VAL_W-1:0]  filt2_reg;
    logic [tmal_pkg::MASK_W-1:0] mask2_reg, mask2_next;
    logic [tmal_pkg::DUTY_W-1:0] duty2_reg, duty2_next;
    logic [tmal_pkg::VAL_W-1:0]  filt3_reg;
    logic [tmal_pkg::MASK_W-1:0] mask3_reg;
    logic [tmal_pkg::VAL_W-1:0]  prod3_reg, prod3_next;
    logic [tmal_pkg::VAL_W-1:0]  filt4_reg;
    logic [tmal_pkg::MASK_W-1:0] mask4_reg;
    logic [tmal_pkg::VAL_W-1:0]  cmp4_reg, cmp4_next;

    logic [tmal_pkg::VAL_W-1:0]   trimmed;
    logic [tmal_pkg::LEVEL_W-1:0] level;
    logic [tmal_pkg::VAL_W+tmal_pkg::DUTY_W-1:0] prod_full;

    // a stage loads when empty or when its content moves on
    assign en4 = !v4_reg || out_ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign grp_ready = en1;

    always_comb begin
        trimmed    = tmal_pkg::div_by_const(grp_num, tmal_pkg::TRIM_M, tmal_pkg::TRIM_SH);
        filt1_next = trimmed - tmal_pkg::VAL_W'(offset);

        level      = tmal_pkg::LEVEL_W'(
            tmal_pkg::div_by_const(filt1_reg, tmal_pkg::LEVEL_M, tmal_pkg::LEVEL_SH));
        mask2_next = tmal_pkg::level_mask(level);
        duty2_next = tmal_pkg::DUTY_W'(
            tmal_pkg::div_by_const(filt1_reg, tmal_pkg::DUTY_M, tmal_pkg::DUTY_SH));

        prod_full  = {{tmal_pkg::DUTY_W{1'b0}}, pwm_period}
                   * {{tmal_pkg::VAL_W{1'b0}}, duty2_reg};
        prod3_next = prod_full[tmal_pkg::VAL_W-1:0];

        cmp4_next  = tmal_pkg::div_by_const(prod3_reg, tmal_pkg::PCT_M, tmal_pkg::PCT_SH);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= grp_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end

        if (en1 && grp_valid) begin
            filt1_reg <= filt1_next;
        end
        if (en2 && v1_reg) begin
            filt2_reg <= filt1_reg;
            mask2_reg <= mask2_next;
            duty2_reg <= duty2_next;
        end
        if (en3 && v2_reg) begin
            filt3_reg <= filt2_reg;
            mask3_reg <= mask2_reg;
            prod3_reg <= prod3_next;
        end
        if (en4 && v3_reg) begin
            filt4_reg <= filt3_reg;
            mask4_reg <= mask3_reg;
            cmp4_reg  <= cmp4_next;
        end
    end

    assign out_valid     = v4_reg;
    assign filtered      = filt4_reg;
    assign led_mask      = mask4_reg;
    assign compare_value = cmp4_reg;

endmodule

// ===== src/trimmed_mean_adc_level_pwm.sv =====
// trimmed_mean_adc_level_pwm: top level of the min/max trimmed mean adc filter
// with led level bar and pwm compare output; holds the configuration registers
// depends on tmal_pkg, tmal_accum, tmal_scale
//
//  channel   direction  handshake            payload
//  s_        in         s_tvalid / s_tready  s_tdata[11:0]  sample
//  m_        out        m_tvalid / m_tready  m_tdata: filtered, led_mask, compare_value
//  cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  one sample item is taken per cycle while s_tready is high; every group of samples
//  closes with one result item that reaches m_ through the group register, then
//  four stages ending in the output register
//  reset is synchronous on aresetn: accumulators clear, offset = 2000,
//  pwm_period = 512, pipeline empties; config writes are always taken
//  a held result stalls only the stages behind it; s_tready drops only when the
//  closing sample of a group finds the group register still occupied
module trimmed_mean_adc_level_pwm (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [tmal_pkg::S_TDATA_W-1:0]   s_tdata,   // [11:0] sample, [15:12] zero

    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tmal_pkg::M_TDATA_W-1:0]   m_tdata,   // [15:0] filtered,
                                                        // [21:16] led_mask,
                                                        // [37:22] compare_value,
                                                        // [39:38] zero

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tmal_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tmal_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // configuration registers
    logic [tmal_pkg::SAMPLE_W-1:0] offset_reg, offset_next;
    logic [tmal_pkg::VAL_W-1:0]    period_reg, period_next;

    // accumulator to pipeline
    logic                       grp_ready;
    logic [tmal_pkg::VAL_W-1:0] grp_num;
    tmal_pkg::acc_stat_t        acc_stat;

    // pipeline outputs
    logic [tmal_pkg::VAL_W-1:0]  filtered;
    logic [tmal_pkg::MASK_W-1:0] led_mask;
    logic [tmal_pkg::VAL_W-1:0]  compare_value;

    assign cfg_ready = 1'b1;

    // register write decode, unknown indexes are dropped
    always_comb begin
        offset_next = offset_reg;
        period_next = period_reg;
        if (cfg_valid) begin
            case (cfg_index)
                tmal_pkg::REG_OFFSET: begin
                    offset_next = cfg_data[tmal_pkg::SAMPLE_W-1:0];
                end
                tmal_pkg::REG_PWM_PERIOD: begin
                    period_next = cfg_data[tmal_pkg::VAL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= tmal_pkg::OFFSET_RESET;
            period_reg <= tmal_pkg::PERIOD_RESET;
        end else begin
            offset_reg <= offset_next;
            period_reg <= period_next;
        end
    end

    // sum, min, max and count over the group
    tmal_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .sample    (s_tdata[tmal_pkg::SAMPLE_W-1:0]),
        .grp_ready (grp_ready),
        .grp_num   (grp_num),
        .stat      (acc_stat)
    );

    // trimmed mean, offset, level bar and pwm compare
    tmal_scale u_scale (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .grp_valid     (acc_stat.grp_valid),
        .grp_ready     (grp_ready),
        .grp_num       (grp_num),
        .offset        (offset_reg),
        .pwm_period    (period_reg),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .filtered      (filtered),
        .led_mask      (led_mask),
        .compare_value (compare_value)
    );

    // pack the result item, zero pad to whole bytes
    assign m_tdata = {2'b00, compare_value, led_mask, filtered};

    // the closing sample of a group always lands in the group register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && acc_stat.count == tmal_pkg::LAST_COUNT)
        |=> acc_stat.grp_valid)
    else $error("closing sample did not load the group register");

    // the count restarts after a closing sample is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && acc_stat.count == tmal_pkg::LAST_COUNT)
        |=> acc_stat.count == '0)
    else $error("sample count did not restart after a group");

    // a lit bar only for a filtered value within the bar's range
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[21:16] != '0) |-> (m_tdata[15:0] < tmal_pkg::LED_LIMIT))
    else $error("led mask lit for an out-of-range level");

    // percent scaling of a 16-bit product stays below 656
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[37:22] <= tmal_pkg::CMP_MAX))
    else $error("compare value above scaled maximum");

endmodule
